/* hw/rtl/ssb_pkg.sv */
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types and constants for the sprite sort batcher.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int MaxGlyphsDef = 64;
  localparam int VertsPerGlyph = 6;
  localparam int KeyW = 17;

  typedef enum logic [1:0] {
    SORT_NONE      = 2'd0,
    SORT_DEPTH_DSC = 2'd1,
    SORT_DEPTH_ASC = 2'd2,
    SORT_TEXTURE   = 2'd3
  } sort_mode_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_CMP,
    ST_WR,
    ST_E_RDO,
    ST_E_RDS,
    ST_E_GOT
  } state_t;

  // Sort key: smaller key goes first.
  function automatic logic [KeyW-1:0] sort_key(input logic [1:0] mode,
                                               input logic [15:0] tex,
                                               input logic [15:0] depth);
    logic [KeyW-1:0] k;
    k = '0;
    case (mode)
      SORT_DEPTH_DSC: k = {1'b0, ~(depth ^ 16'h8000)};
      SORT_DEPTH_ASC: k = {1'b0, depth ^ 16'h8000};
      SORT_TEXTURE:   k = {1'b0, tex};
      default:        k = '0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sprite_sort_batcher.sv */
// ----------------------------------------------------------------------------
// sprite_sort_batcher
// Stores glyphs, sorts them stably and emits them grouped in texture batches.
// ----------------------------------------------------------------------------
// Input items: in_tuser is the command (0 load, 1 end), in_tdata carries
// texture and depth. Loads are taken one per cycle while idle; loads past
// MAX_GLYPHS are dropped and flagged on the next emission.
// An end item starts a rank pass: one shared key comparator checks each
// glyph against every stored glyph, writing the sorted order to a small
// memory. Emission then reads order and store for each glyph in turn;
// out_tlast marks the final item. in_tready is low from the end item
// until the final item is loaded into the output register. An end with
// no stored glyphs emits nothing.
// The output register holds while out_tready is low; the whole walk stalls.
// Reset (rst_n low, synchronous) empties the store, clears the overflow
// flag and the output valid, and sets sort_mode to ascending texture.
// cfg_we writes sort_mode from cfg_wdata; write only while idle.
// ----------------------------------------------------------------------------
module sprite_sort_batcher
  import ssb_pkg::*;
#(
  parameter int MAX_GLYPHS = MaxGlyphsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // texture_id[15:0], depth_key[31:16]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // glyph_index[5:0], glyph_texture[21:6],
                                  // batch_offset[30:22], batch_vertex_count[39:31]
  output logic [1:0]  out_tuser,  // batch_end[0], overflowed[1]
  output logic        out_tlast
);

  localparam int IdxW = $clog2(MAX_GLYPHS);
  localparam int CntW = $clog2(MAX_GLYPHS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_GLYPHS);

  state_t state_r, state_nxt;
  logic [1:0] mode_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;

  logic [31:0] store_mem [MAX_GLYPHS];
  logic [IdxW-1:0] ord_mem [MAX_GLYPHS];
  logic [31:0] st_rd_r;
  logic [IdxW-1:0] ord_rd_r;
  logic [IdxW-1:0] st_addr, ord_addr;
  logic st_we, ord_we;

  logic [IdxW-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic [KeyW-1:0] key_i_r, key_i_nxt, key_j;
  logic [IdxW-1:0] g_r, g_nxt, k_r, k_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [IdxW-1:0] pend_idx_r, pend_idx_nxt, pend_pos_r, pend_pos_nxt;
  logic [IdxW-1:0] pend_start_r, pend_start_nxt;
  logic [15:0] pend_tex_r, pend_tex_nxt;

  logic ov_r, ov_nxt, ot_last_r, ot_last_nxt, ot_end_r, ot_end_nxt, ot_ovf_r, ot_ovf_nxt;
  logic [5:0] ot_idx_r, ot_idx_nxt;
  logic [15:0] ot_tex_r, ot_tex_nxt;
  logic [8:0] ot_off_r, ot_off_nxt, ot_cnt_r, ot_cnt_nxt;

  logic in_acc, out_free, last_i, last_j, last_k, tex_diff;
  logic [IdxW-1:0] n_m1;
  logic [8:0] start9, len9;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;
  assign n_m1     = IdxW'(cnt_r - CntW'(1));
  assign last_i   = (i_r == n_m1);
  assign last_j   = (j_r == n_m1);
  assign last_k   = (k_r == n_m1);
  assign key_j    = sort_key(mode_r, st_rd_r[15:0], st_rd_r[31:16]);
  assign tex_diff = (st_rd_r[15:0] != pend_tex_r);
  assign start9   = 9'(pend_start_r);
  assign len9     = 9'(pend_pos_r) - 9'(pend_start_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_addr] <= in_tdata;
    st_rd_r <= store_mem[st_addr];
    if (ord_we) ord_mem[rank_r] <= i_r;
    ord_rd_r <= ord_mem[ord_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_tuser == CMD_END && cnt_r != '0) state_nxt = ST_RD_I;
      ST_RD_I:  state_nxt = ST_LD_I;
      ST_LD_I:  state_nxt = ST_CMP;
      ST_CMP:   if (last_j) state_nxt = ST_WR;
      ST_WR:    state_nxt = last_i ? ST_E_RDO : ST_RD_I;
      ST_E_RDO: state_nxt = ST_E_RDS;
      ST_E_RDS: state_nxt = ST_E_GOT;
      ST_E_GOT: begin
        // leave once the final glyph has been handed to the output
        if (pend_v_r && out_free && last_k && pend_pos_r == k_r) state_nxt = ST_IDLE;
        else if (!pend_v_r || out_free) state_nxt = last_k ? ST_E_GOT : ST_E_RDO;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    i_nxt = i_r;
    j_nxt = j_r;
    rank_nxt = rank_r;
    key_i_nxt = key_i_r;
    g_nxt = g_r;
    k_nxt = k_r;
    pend_v_nxt = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_pos_nxt = pend_pos_r;
    pend_start_nxt = pend_start_r;
    pend_tex_nxt = pend_tex_r;
    ov_nxt = ov_r && !out_tready;
    ot_last_nxt = ot_last_r;
    ot_end_nxt = ot_end_r;
    ot_ovf_nxt = ot_ovf_r;
    ot_idx_nxt = ot_idx_r;
    ot_tex_nxt = ot_tex_r;
    ot_off_nxt = ot_off_r;
    ot_cnt_nxt = ot_cnt_r;
    st_we = 1'b0;
    ord_we = 1'b0;
    st_addr = IdxW'(cnt_r);
    ord_addr = k_r;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_LOAD) begin
            if (cnt_r < MaxCnt) begin
              st_we = 1'b1;
              cnt_nxt = cnt_r + CntW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (cnt_r == '0) begin
            ovf_nxt = 1'b0;
          end
        end
        i_nxt = '0;
        k_nxt = '0;
        pend_v_nxt = 1'b0;
      end
      ST_RD_I: begin
        st_addr = i_r;
        rank_nxt = '0;
      end
      ST_LD_I: begin
        key_i_nxt = key_j;
        st_addr = '0;
        j_nxt = '0;
      end
      ST_CMP: begin
        st_addr = j_r + IdxW'(1);
        j_nxt = j_r + IdxW'(1);
        if (key_j < key_i_r || (key_j == key_i_r && j_r < i_r))
          rank_nxt = rank_r + IdxW'(1);
      end
      ST_WR: begin
        ord_we = 1'b1;
        i_nxt = i_r + IdxW'(1);
      end
      ST_E_RDO: begin
        ord_addr = k_r;
      end
      ST_E_RDS: begin
        st_addr = ord_rd_r;
        g_nxt = ord_rd_r;
      end
      ST_E_GOT: begin
        st_addr = g_r;
        if (pend_v_r && out_free) begin
          // Emit the held glyph; it ends its batch if texture changes here,
          // or if it is the final one.
          ov_nxt = 1'b1;
          ot_idx_nxt = 6'(pend_idx_r);
          ot_tex_nxt = pend_tex_r;
          ot_off_nxt = (start9 << 2) + (start9 << 1);
          ot_ovf_nxt = ovf_r;
          if (last_k && pend_pos_r == k_r) begin
            ot_end_nxt = 1'b1;
            ot_last_nxt = 1'b1;
            ot_cnt_nxt = (len9 << 2) + (len9 << 1);
            pend_v_nxt = 1'b0;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end else begin
            ot_end_nxt = tex_diff;
            ot_last_nxt = 1'b0;
            ot_cnt_nxt = tex_diff ? (len9 << 2) + (len9 << 1) : 9'd0;
            pend_idx_nxt = g_r;
            pend_tex_nxt = st_rd_r[15:0];
            pend_pos_nxt = k_r;
            pend_start_nxt = tex_diff ? k_r : pend_start_r;
            if (!last_k) k_nxt = k_r + IdxW'(1);
          end
        end else if (!pend_v_r) begin
          pend_v_nxt = 1'b1;
          pend_idx_nxt = g_r;
          pend_tex_nxt = st_rd_r[15:0];
          pend_pos_nxt = k_r;
          pend_start_nxt = k_r;
          if (!last_k) k_nxt = k_r + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r <= SORT_TEXTURE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    rank_r <= rank_nxt;
    key_i_r <= key_i_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_pos_r <= pend_pos_nxt;
    pend_start_r <= pend_start_nxt;
    pend_tex_r <= pend_tex_nxt;
    ot_last_r <= ot_last_nxt;
    ot_end_r <= ot_end_nxt;
    ot_ovf_r <= ot_ovf_nxt;
    ot_idx_r <= ot_idx_nxt;
    ot_tex_r <= ot_tex_nxt;
    ot_off_r <= ot_off_nxt;
    ot_cnt_r <= ot_cnt_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {ot_cnt_r, ot_off_r, ot_tex_r, ot_idx_r};
  assign out_tuser  = {ot_ovf_r, ot_end_r};
  assign out_tlast  = ot_last_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MaxCnt)
    else $error("glyph count above capacity");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("final item does not close a batch");
  a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[39:31] != 9'd0) == out_tuser[0]))
    else $error("vertex count and batch end disagree");
  a_rank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> CntW'(rank_r) < cnt_r)
    else $error("rank out of range");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sprite_sort_batcher: glyph loads and end items are
// streamed in, a sorting/batching predictor builds the expected item stream,
// and every output item is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import ssb_pkg::*;

  localparam int NGLYPH     = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 220;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] tex;
    logic [8:0]  offset;
    logic [8:0]  vcount;
    logic        bend;
    logic        ovf;
    logic        last;
  } glyph_res_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] tex;
    logic [15:0] depth;
    bit          typed;
    glyph_res_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  sprite_sort_batcher dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // predictor state
  logic [15:0] store_tex[$];
  logic [15:0] store_depth[$];
  logic        ovf_flag;
  sort_mode_t  cur_mode;
  glyph_res_t  expected_q[$];

  int errors, items_sent, results_seen, ends_sent, ovf_seen, idle_cycles;
  int hold_cycles;
  int hold_req, hold_done;
  int burst_left;
  bit stall_on;
  int stall_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, exp);
    errors++;
  endtask

  function automatic bit goes_first(input int a, input int b);
    case (cur_mode)
      SORT_DEPTH_DSC: return $signed(store_depth[a]) > $signed(store_depth[b]);
      SORT_DEPTH_ASC: return $signed(store_depth[a]) < $signed(store_depth[b]);
      SORT_TEXTURE:   return store_tex[a] < store_tex[b];
      default:        return 1'b0;
    endcase
  endfunction

  task automatic predict_batches();
    int order[NGLYPH];
    int n, cur, j, start, g;
    glyph_res_t r;
    n = store_tex.size();
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = 1; i < n; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && goes_first(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    start = 0;
    for (int k = 0; k < n; k++) begin
      g = order[k];
      if (k > 0 && store_tex[g] != store_tex[order[k-1]]) start = k;
      r.idx    = g[5:0];
      r.tex    = store_tex[g];
      r.offset = 9'(start * VertsPerGlyph);
      r.bend   = (k + 1 == n) || (store_tex[order[k+1]] != store_tex[g]);
      r.vcount = r.bend ? 9'((k - start + 1) * VertsPerGlyph) : 9'd0;
      r.ovf    = ovf_flag;
      r.last   = (k + 1 == n);
      expected_q.push_back(r);
    end
    store_tex.delete();
    store_depth.delete();
    ovf_flag = 1'b0;
  endtask

  task automatic model_item(input cmd_t cmd, input logic [15:0] tex, input logic [15:0] dep);
    if (cmd == CMD_LOAD) begin
      if (store_tex.size() < NGLYPH) begin
        store_tex.push_back(tex);
        store_depth.push_back(dep);
      end else ovf_flag = 1'b1;
    end else begin
      ends_sent++;
      predict_batches();
    end
  endtask

  // drive one item; bursts of random length, random gaps between bursts
  task automatic send_item(input cmd_t cmd, input logic [15:0] tex, input logic [15:0] dep);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {dep, tex};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    model_item(cmd, tex, dep);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_mode(input sort_mode_t m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_mode = m;
  endtask

  task automatic rand_batch(input int n, input bit narrow);
    logic [15:0] t, d;
    for (int i = 0; i < n; i++) begin
      t = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
      case ($urandom_range(0, 3))
        0: d = 16'h8000;
        1: d = 16'h7fff;
        2: d = 16'($urandom_range(0, 2));
        default: d = 16'($urandom);
      endcase
      send_item(CMD_LOAD, t, d);
    end
    send_item(CMD_END, 16'($urandom), 16'($urandom));
  endtask

  // receiver: stall pattern toggles between stretches, plus long holds on request;
  // a hold counts only cycles with an item waiting
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      hold_cycles <= 0;
      hold_done   <= 0;
      stall_on    <= 1'b0;
      stall_phase <= 100;
    end else if (hold_req != hold_done) begin
      hold_done   <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      if (out_tvalid) hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_on    <= !stall_on;
        stall_phase <= $urandom_range(50, 300);
      end else stall_phase <= stall_phase - 1;
      out_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    glyph_res_t e, g;
    if (rst_n && out_tvalid && out_tready) begin
      g = {out_tdata[5:0], out_tdata[21:6], out_tdata[30:22], out_tdata[39:31],
           out_tuser[0], out_tuser[1], out_tlast};
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected item", 32'(g.idx), 0);
      end else begin
        e = expected_q.pop_front();
        if (g.ovf) ovf_seen++;
        if (g.idx != e.idx) report("glyph_index", 32'(g.idx), 32'(e.idx));
        if (g.tex != e.tex) report("glyph_texture", 32'(g.tex), 32'(e.tex));
        if (g.offset != e.offset) report("batch_offset", 32'(g.offset), 32'(e.offset));
        if (g.vcount != e.vcount) report("batch_vertex_count", 32'(g.vcount), 32'(e.vcount));
        if (g.bend != e.bend) report("batch_end", 32'(g.bend), 32'(e.bend));
        if (g.ovf != e.ovf) report("overflowed", 32'(g.ovf), 32'(e.ovf));
        if (g.last != e.last) report("last", 32'(g.last), 32'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("ERROR: watchdog timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int qn;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    errors = 0; items_sent = 0; ends_sent = 0;
    hold_req = 0; burst_left = 0;
    ovf_flag = 1'b0;
    cur_mode = SORT_TEXTURE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, reset sort mode (ascending texture)
    row = '{CMD_END, 16'h1234, 16'h0000, 1'b0, '0};
    rows.push_back(row);                                   // end on empty store
    row = '{CMD_LOAD, 16'hffff, 16'h7fff, 1'b0, '0};
    rows.push_back(row);
    row = '{CMD_END, 16'h0000, 16'h0000, 1'b1,
            '{6'd0, 16'hffff, 9'd0, 9'd6, 1'b1, 1'b0, 1'b1}};
    rows.push_back(row);
    row = '{CMD_LOAD, 16'h0000, 16'h8000, 1'b0, '0};
    rows.push_back(row);
    row = '{CMD_END, 16'hffff, 16'hffff, 1'b1,
            '{6'd0, 16'h0000, 9'd0, 9'd6, 1'b1, 1'b0, 1'b1}};
    rows.push_back(row);
    row = '{CMD_LOAD, 16'h0005, 16'h8000, 1'b0, '0}; rows.push_back(row);
    row = '{CMD_LOAD, 16'h0000, 16'h0000, 1'b0, '0}; rows.push_back(row);
    row = '{CMD_LOAD, 16'h0005, 16'h7fff, 1'b0, '0}; rows.push_back(row);
    row = '{CMD_LOAD, 16'h0000, 16'hffff, 1'b0, '0}; rows.push_back(row);
    row = '{CMD_LOAD, 16'hffff, 16'h0100, 1'b0, '0}; rows.push_back(row);
    row = '{CMD_LOAD, 16'h0005, 16'h0001, 1'b0, '0}; rows.push_back(row);
    row = '{CMD_END, 16'h0000, 16'h0000, 1'b0, '0};  rows.push_back(row);
    foreach (rows[i]) begin
      qn = store_tex.size();
      send_item(rows[i].cmd, rows[i].tex, rows[i].depth);
      if (rows[i].typed) begin
        if (qn == 1) expected_q[$] = rows[i].res;
        else report("typed row count", 32'(qn), 1);
      end
    end
    drain();

    // store overflow with a long output hold while inputs keep coming
    write_mode(SORT_DEPTH_DSC);
    rand_batch(NGLYPH + 3, 1'b1);
    hold_req++;
    rand_batch(5, 1'b1);
    drain();

    // random phases over all sort modes
    while (items_sent < RAND_ITEMS - 60) begin
      write_mode(sort_mode_t'($urandom_range(0, 3)));
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 11) == 0) rand_batch($urandom_range(60, 68), $urandom_range(0, 1));
        else rand_batch($urandom_range(0, 10), $urandom_range(0, 3) != 0);
      end
      drain();
    end
    write_mode(SORT_NONE);
    rand_batch(8, 1'b1);
    drain();
    write_mode(SORT_TEXTURE);
    rand_batch(8, 1'b1);
    drain();
    repeat (100) @(posedge clk);

    $display("Sent %0d items (%0d end items), checked %0d output items", items_sent,
             ends_sent, results_seen);
    $display("All four sort modes, store overflow (%0d flagged items), long output holds",
             ovf_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("ERROR: %0d mismatches, %0d items still expected", errors, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
